// File: rtl/core/ssbe_pkg.sv
package ssbe_pkg;

   localparam int BANDS      = 256;
   localparam int BAND_AW    = $clog2(BANDS);
   localparam logic [7:0] BAND_TOP = 8'((BANDS - 1 > 255) ? 255 : BANDS - 1);

   localparam int SINE_DEPTH = 1024;
   localparam int SINE_IW    = $clog2(SINE_DEPTH);
   localparam int SINE_AW    = SINE_IW + 1;

   localparam int ENERGY_W   = 48;
   localparam int DIV_STEPS  = 32;
   localparam int DIV_CW     = $clog2(DIV_STEPS);

   localparam logic [31:0] START_INC_RST  = 32'd0;
   localparam logic [19:0] INC_STEP_RST   = 20'd1864;
   localparam logic [31:0] END_INC_RST    = 32'h8000_0000;
   localparam logic [31:0] BAND_WIDTH_RST = 32'd8388608;
   localparam logic [19:0] STEP_DIV_RST   = 20'(INC_STEP_RST / BAND_WIDTH_RST);
   localparam logic [19:0] STEP_MOD_RST   = 20'(INC_STEP_RST % BAND_WIDTH_RST);

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_READ   = 2'd1,
      OP_START  = 2'd2
   } ssbe_op_type;

   typedef enum logic [1:0] {
      REG_START_INC  = 2'd0,
      REG_INC_STEP   = 2'd1,
      REG_END_INC    = 2'd2,
      REG_BAND_WIDTH = 2'd3
   } ssbe_reg_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_STEP,
      DIV_FRAC
   } ssbe_div_state_type;

   typedef struct packed {
      logic                 emit;
      logic                 count;
      logic                 rd;
      logic                 rd_ok;
      logic                 clr;
      logic [BAND_AW-1:0]   addr;
      logic [SINE_AW-1:0]   rom_addr;
      logic                 neg;
      logic signed [15:0]   sample;
      logic [7:0]           band;
      logic                 done;
   } ssbe_item_type;

   typedef struct packed {
      logic s1_valid;
      logic take_ok;
   } ssbe_pipe_type;

   typedef logic [14:0] sine_rom_type [0:SINE_DEPTH];

   function automatic sine_rom_type sine_rom_build();
      sine_rom_type rom;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] s;
      logic [63:0] e;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
         x    = (64'd1686629713 * 64'(k)) / 64'(SINE_DEPTH);
         x2   = (x * x) >> 30;
         term = x;
         pos  = x;
         neg  = 64'd0;
         for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) neg = neg + term;
            else pos = pos + term;
         end
         s = (pos > neg) ? pos - neg : 64'd0;
         e = (s * 64'd32767 + 64'd536870912) >> 30;
         if (e > 64'd32767) e = 64'd32767;
         rom[k] = 15'(e);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = sine_rom_build();

endpackage

// File: rtl/core/ssbe_div.sv
module ssbe_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   import ssbe_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic [31:0]       quo_ff;
   logic [31:0]       rem_ff;
   logic [32:0]       dvs_ff;

   logic [32:0] trial;
   logic        ge;
   logic [31:0] rem_step;

   assign trial    = {rem_ff, quo_ff[31]};
   assign ge       = trial >= dvs_ff;
   assign rem_step = ge ? 32'(trial - dvs_ff) : trial[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CW'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[30:0], ge};
         rem_ff <= rem_step;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/core/ssbe_sweep.sv
module ssbe_sweep (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data,
   input  logic                   accept,
   input  logic [1:0]             opcode,
   input  logic signed [15:0]     in_sample,
   input  logic [7:0]             read_band,
   output ssbe_pkg::ssbe_item_type item,
   output logic                   busy
);
   import ssbe_pkg::*;

   logic [31:0] start_inc_ff;
   logic [19:0] step_ff;
   logic [31:0] end_inc_ff;
   logic [31:0] bw_ff;

   logic [31:0] phase_ff, phase_in;
   logic [31:0] inc_ff, inc_in;
   logic [31:0] frac_true_ff, frac_true_in;
   logic [31:0] frac_rem_ff, frac_rem_in;
   logic [31:0] frac_quo_ff, frac_quo_in;
   logic [19:0] step_div_ff, step_div_in;
   logic [19:0] step_mod_ff, step_mod_in;
   logic [7:0]  band_ff, band_in;
   logic        sweeping_ff, sweeping_in;
   logic        finished_ff, finished_in;
   logic        pend_ff, pend_in;
   ssbe_div_state_type state_ff, state_in;

   logic        div_start;
   logic [31:0] div_dividend;
   logic        div_done;
   logic [31:0] div_quo;
   logic [31:0] div_rem;

   logic [32:0]        bw_ext;
   logic [32:0]        frac_sum;
   logic               frac_carry;
   logic [31:0]        frac_next;
   logic [33:0]        adv;
   logic [33:0]        band_sum;
   logic [7:0]         band_next;
   logic [32:0]        inc_sum;
   logic               stop;
   logic [31:0]        inc_stop;
   logic               is_sample;
   logic               is_read;
   logic               is_start;
   logic [SINE_IW-1:0] sine_idx;
   logic               div_reg_write;

   ssbe_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (bw_ext),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_inc_ff <= START_INC_RST;
         step_ff      <= INC_STEP_RST;
         end_inc_ff   <= END_INC_RST;
         bw_ff        <= BAND_WIDTH_RST;
      end else if (csr_write) begin
         unique case (ssbe_reg_type'(csr_index))
            REG_START_INC:  start_inc_ff <= csr_data;
            REG_INC_STEP:   step_ff      <= csr_data[19:0];
            REG_END_INC:    end_inc_ff   <= csr_data;
            REG_BAND_WIDTH: bw_ff        <= csr_data;
         endcase
      end
   end

   assign div_reg_write = csr_write && (ssbe_reg_type'(csr_index) == REG_INC_STEP ||
                                        ssbe_reg_type'(csr_index) == REG_BAND_WIDTH);

   assign bw_ext     = (bw_ff == '0) ? {1'b1, 32'd0} : {1'b0, bw_ff};
   assign frac_sum   = {1'b0, frac_rem_ff} + 33'(step_mod_ff);
   assign frac_carry = frac_sum >= bw_ext;
   assign frac_next  = frac_carry ? 32'(frac_sum - bw_ext) : frac_sum[31:0];
   assign adv        = 34'(step_div_ff) + 34'(frac_quo_ff) + 34'(frac_carry);
   assign band_sum   = adv + 34'(band_ff);
   assign band_next  = (band_sum > 34'(BAND_TOP)) ? BAND_TOP : band_sum[7:0];
   assign inc_sum    = {1'b0, inc_ff} + 33'(step_ff);
   assign stop       = inc_sum >= {1'b0, end_inc_ff};
   assign inc_stop   = inc_sum[32] ? '1 : inc_sum[31:0];
   assign sine_idx   = phase_ff[29 -: SINE_IW];

   always_comb begin
      is_sample = 1'b0;
      is_read   = 1'b0;
      is_start  = 1'b0;
      unique case (ssbe_op_type'(opcode))
         OP_SAMPLE: is_sample = 1'b1;
         OP_READ:   is_read   = 1'b1;
         OP_START:  is_start  = 1'b1;
         default:   ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      div_start    = 1'b0;
      div_dividend = 32'(step_ff);
      phase_in     = phase_ff;
      inc_in       = inc_ff;
      frac_true_in = frac_true_ff;
      frac_rem_in  = frac_rem_ff;
      frac_quo_in  = frac_quo_ff;
      step_div_in  = step_div_ff;
      step_mod_in  = step_mod_ff;
      band_in      = band_ff;
      sweeping_in  = sweeping_ff;
      finished_in  = finished_ff;

      unique case (state_ff)
         DIV_IDLE: begin
            if (pend_ff) begin
               div_start = 1'b1;
               pend_in   = 1'b0;
               state_in  = DIV_STEP;
            end
         end
         DIV_STEP: begin
            div_dividend = frac_true_ff;
            if (div_done) begin
               step_div_in = div_quo[19:0];
               step_mod_in = div_rem[19:0];
               div_start   = 1'b1;
               state_in    = DIV_FRAC;
            end
         end
         DIV_FRAC: begin
            if (div_done) begin
               frac_quo_in = div_quo;
               frac_rem_in = div_rem;
               state_in    = DIV_IDLE;
            end
         end
         default: state_in = DIV_IDLE;
      endcase
      if (div_reg_write) pend_in = 1'b1;

      if (accept && is_start) begin
         phase_in     = '0;
         inc_in       = start_inc_ff;
         frac_true_in = '0;
         frac_rem_in  = '0;
         frac_quo_in  = '0;
         band_in      = '0;
         sweeping_in  = 1'b1;
         finished_in  = 1'b0;
      end else if (accept && is_sample && sweeping_ff) begin
         phase_in = phase_ff + inc_ff;
         if (stop) begin
            inc_in      = inc_stop;
            sweeping_in = 1'b0;
            finished_in = 1'b1;
         end else begin
            inc_in       = inc_sum[31:0];
            frac_true_in = frac_next;
            frac_rem_in  = frac_next;
            frac_quo_in  = '0;
            band_in      = band_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DIV_IDLE;
         pend_ff      <= 1'b0;
         phase_ff     <= '0;
         inc_ff       <= '0;
         frac_true_ff <= '0;
         frac_rem_ff  <= '0;
         frac_quo_ff  <= '0;
         step_div_ff  <= STEP_DIV_RST;
         step_mod_ff  <= STEP_MOD_RST;
         band_ff      <= '0;
         sweeping_ff  <= 1'b0;
         finished_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         phase_ff     <= phase_in;
         inc_ff       <= inc_in;
         frac_true_ff <= frac_true_in;
         frac_rem_ff  <= frac_rem_in;
         frac_quo_ff  <= frac_quo_in;
         step_div_ff  <= step_div_in;
         step_mod_ff  <= step_mod_in;
         band_ff      <= band_in;
         sweeping_ff  <= sweeping_in;
         finished_ff  <= finished_in;
      end
   end

   always_comb begin
      item.emit     = is_sample && sweeping_ff;
      item.count    = is_sample && sweeping_ff && !stop;
      item.rd       = is_read;
      item.rd_ok    = 32'(read_band) < BANDS;
      item.clr      = is_start;
      item.addr     = item.count ? BAND_AW'(band_next) : BAND_AW'(read_band);
      item.rom_addr = phase_ff[30] ? SINE_AW'(SINE_DEPTH) - {1'b0, sine_idx}
                                   : {1'b0, sine_idx};
      item.neg      = phase_ff[31];
      item.sample   = in_sample;
      item.band     = band_in;
      item.done     = finished_in;
   end

   assign busy = pend_ff || (state_ff != DIV_IDLE);

endmodule

// File: rtl/core/ssbe_store.sv
module ssbe_store (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  ssbe_pkg::ssbe_item_type item,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic signed [15:0]     rsp_out_sample,
   output logic [47:0]            rsp_band_energy,
   output logic                   rsp_sweep_done,
   output logic [7:0]             rsp_current_band,
   output ssbe_pkg::ssbe_pipe_type pipe
);
   import ssbe_pkg::*;

   logic [ENERGY_W-1:0] energy_mem [BANDS];
   logic [BANDS-1:0]    valid_ff;

   logic                s1_valid_ff;
   ssbe_item_type       s1_ff;
   logic [ENERGY_W-1:0] rd_data_ff;
   logic                rd_vld_ff;
   logic [14:0]         rom_ff;
   logic [30:0]         sq_ff;

   logic                lw_valid_ff;
   logic [BAND_AW-1:0]  lw_addr_ff;
   logic [ENERGY_W-1:0] lw_data_ff;

   logic                rsp_valid_ff;
   logic signed [15:0]  rsp_sample_ff;
   logic [47:0]         rsp_energy_ff;
   logic                rsp_done_ff;
   logic [7:0]          rsp_band_ff;

   logic signed [31:0]  prod;
   logic                s2_free;
   logic                s1_adv;
   logic [ENERGY_W-1:0] base;
   logic [ENERGY_W:0]   sum;
   logic [ENERGY_W-1:0] new_energy;
   logic signed [15:0]  mag;
   logic signed [15:0]  sample_out;

   assign prod    = item.sample * item.sample;
   assign s2_free = !rsp_valid_ff || !rsp_stall;
   assign s1_adv  = s1_valid_ff && s2_free;

   assign base = (lw_valid_ff && lw_addr_ff == s1_ff.addr) ? lw_data_ff :
                 (rd_vld_ff ? rd_data_ff : '0);
   assign sum        = {1'b0, base} + (ENERGY_W + 1)'(sq_ff);
   assign new_energy = sum[ENERGY_W] ? '1 : sum[ENERGY_W-1:0];
   assign mag        = {1'b0, rom_ff};
   assign sample_out = !s1_ff.emit ? 16'sd0 : (s1_ff.neg ? -mag : mag);

   always_ff @(posedge clock) begin
      if (accept) rd_data_ff <= energy_mem[item.addr];
      if (s1_adv && s1_ff.count) energy_mem[s1_ff.addr] <= new_energy;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff  <= item;
         rom_ff <= SINE_ROM[item.rom_addr];
         sq_ff  <= prod[30:0];
      end
      if (s1_adv && s1_ff.count) begin
         lw_addr_ff <= s1_ff.addr;
         lw_data_ff <= new_energy;
      end
      if (s1_adv) begin
         rsp_sample_ff <= sample_out;
         rsp_energy_ff <= (s1_ff.rd && s1_ff.rd_ok) ? base : '0;
         rsp_done_ff   <= s1_ff.done;
         rsp_band_ff   <= s1_ff.band;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         lw_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
            rd_vld_ff   <= valid_ff[item.addr];
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (accept && item.clr) begin
            valid_ff    <= '0;
            lw_valid_ff <= 1'b0;
         end else if (s1_adv && s1_ff.count) begin
            valid_ff[s1_ff.addr] <= 1'b1;
            lw_valid_ff          <= 1'b1;
         end
         if (s1_adv) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign pipe.s1_valid    = s1_valid_ff;
   assign pipe.take_ok     = !s1_valid_ff || s2_free;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_sample   = rsp_sample_ff;
   assign rsp_band_energy  = rsp_energy_ff;
   assign rsp_sweep_done   = rsp_done_ff;
   assign rsp_current_band = rsp_band_ff;

endmodule

// File: rtl/core/swept_sine_band_energy.sv
// Swept-sine band-energy recorder. Takes one word per clock while req_stall is low: a start
// word clears the 256-band energy store (through per-band valid flags, at once) and begins a
// linear chirp, a sample word returns the next sine sample while sweeping and adds the squared
// input to the current band, a read word returns one band's 48-bit saturated energy. A result
// passes a stage register and then the output register: the accepting edge reads the energy
// memory and sine ROM into the stage, and once the output register is free the read-modify-write
// updates the band and fills the output register, with the last write forwarded to a following
// word of the same band. Writing increment_step or band_width starts an iterative 32-step
// divider run twice, holding off new words until both runs finish.
module swept_sine_band_energy (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic signed [15:0] req_in_sample,
   input  logic [7:0]         req_read_band,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_sample,
   output logic [47:0]        rsp_band_energy,
   output logic               rsp_sweep_done,
   output logic [7:0]         rsp_current_band
);
   import ssbe_pkg::*;

   ssbe_item_type item;
   ssbe_pipe_type pipe;
   logic          busy;
   logic          accept;

   assign req_stall = busy || !pipe.take_ok;
   assign accept    = req_valid && !req_stall;

   ssbe_sweep u_sweep (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (accept),
      .opcode    (req_opcode),
      .in_sample (req_in_sample),
      .read_band (req_read_band),
      .item      (item),
      .busy      (busy)
   );

   ssbe_store u_store (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .item             (item),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_band_energy  (rsp_band_energy),
      .rsp_sweep_done   (rsp_sweep_done),
      .rsp_current_band (rsp_current_band),
      .pipe             (pipe)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_band_energy != '0 |-> rsp_out_sample == 16'sd0)
      else $error("energy and sine sample in one word");

   assert property (@(posedge clock) disable iff (reset)
      csr_write && (ssbe_reg_type'(csr_index) == REG_INC_STEP ||
                    ssbe_reg_type'(csr_index) == REG_BAND_WIDTH) |=> req_stall)
      else $error("word taken before band divider finished");

   assert property (@(posedge clock) disable iff (reset)
      accept && pipe.s1_valid |-> !rsp_valid || !rsp_stall)
      else $error("word taken over a held stage");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_current_band <= BAND_TOP)
      else $error("band index past last band");

endmodule

// File: bench/band_energy_checker.sv
`timescale 1ns / 1ps

module band_energy_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic signed [15:0] req_in_sample,
   input  logic [7:0]         req_read_band,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_out_sample,
   input  logic [47:0]        rsp_band_energy,
   input  logic               rsp_sweep_done,
   input  logic [7:0]         rsp_current_band,
   output int                 fail_count,
   output int                 pending_count
);
   import ssbe_pkg::*;

   localparam int          LAST_BAND  = (BANDS - 1 > 255) ? 255 : BANDS - 1;
   localparam logic [47:0] ENERGY_CAP = '1;

   typedef struct packed {
      logic signed [15:0] tone;
      logic [47:0]        energy;
      logic               done;
      logic [7:0]         band;
   } sweep_result_type;

   sweep_result_type expected_words [$];

   logic [14:0] quarter_wave [0:SINE_DEPTH];

   logic [31:0] cfg_start;
   logic [19:0] cfg_step;
   logic [31:0] cfg_end;
   logic [31:0] cfg_width;

   logic [31:0] phase_acc;
   logic [31:0] phase_inc;
   logic [31:0] band_frac;
   logic [7:0]  band_idx;
   logic        sweeping;
   logic        finished;
   logic [47:0] energy_bank [BANDS];

   function automatic logic [14:0] wave_level(input int k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] s;
      logic [63:0] e;
      x    = (64'd1686629713 * 64'(k)) / 64'(SINE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      neg  = 64'd0;
      for (int n = 1; n <= 8; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      s = (pos > neg) ? pos - neg : 64'd0;
      e = (s * 64'd32767 + 64'd536870912) >> 30;
      if (e > 64'd32767) begin
         e = 64'd32767;
      end
      return 15'(e);
   endfunction

   function automatic logic signed [15:0] tone_at(input logic [31:0] phase);
      logic [63:0] slot;
      logic [15:0] mag;
      slot = (64'(phase[29:0]) * 64'(SINE_DEPTH)) >> 30;
      if (slot > 64'(SINE_DEPTH)) begin
         slot = 64'(SINE_DEPTH);
      end
      if (phase[30]) begin
         mag = 16'(quarter_wave[SINE_DEPTH - int'(slot)]);
      end else begin
         mag = 16'(quarter_wave[int'(slot)]);
      end
      return phase[31] ? -mag : mag;
   endfunction

   initial begin
      fail_count    = 0;
      pending_count = 0;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
         quarter_wave[k] = wave_level(k);
      end
   end

   always @(posedge clock) begin : watch
      sweep_result_type seen;
      sweep_result_type want;
      logic [32:0]   inc_sum;
      logic [32:0]   frac_sum;
      logic [32:0]   span;
      logic [32:0]   adv;
      logic [33:0]   next_band;
      logic [31:0]   square;
      logic [48:0]   acc;
      if (reset) begin
         cfg_start  = START_INC_RST;
         cfg_step   = INC_STEP_RST;
         cfg_end    = END_INC_RST;
         cfg_width  = BAND_WIDTH_RST;
         phase_acc  = '0;
         phase_inc  = '0;
         band_frac  = '0;
         band_idx   = '0;
         sweeping   = 1'b0;
         finished   = 1'b0;
         for (int b = 0; b < BANDS; b++) begin
            energy_bank[b] = '0;
         end
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_out_sample, rsp_band_energy, rsp_sweep_done, rsp_current_band};
            if (expected_words.size() == 0) begin
               $error("result word with no expectation waiting: sample %0d energy %0d",
                      seen.tone, seen.energy);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (seen.tone !== want.tone) begin
                  $error("out_sample: expected %0d, got %0d", want.tone, seen.tone);
                  fail_count++;
               end
               if (seen.energy !== want.energy) begin
                  $error("band_energy: expected %0d, got %0d", want.energy, seen.energy);
                  fail_count++;
               end
               if (seen.done !== want.done) begin
                  $error("sweep_done: expected %0d, got %0d", want.done, seen.done);
                  fail_count++;
               end
               if (seen.band !== want.band) begin
                  $error("current_band: expected %0d, got %0d", want.band, seen.band);
                  fail_count++;
               end
            end
         end

         if (csr_write) begin
            case (ssbe_reg_type'(csr_index))
               REG_START_INC:  cfg_start = csr_data;
               REG_INC_STEP:   cfg_step  = csr_data[19:0];
               REG_END_INC:    cfg_end   = csr_data;
               REG_BAND_WIDTH: cfg_width = csr_data;
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            want.tone   = '0;
            want.energy = '0;
            case (ssbe_op_type'(req_opcode))
               OP_START: begin
                  for (int b = 0; b < BANDS; b++) begin
                     energy_bank[b] = '0;
                  end
                  phase_acc = '0;
                  phase_inc = cfg_start;
                  band_frac = '0;
                  band_idx  = '0;
                  sweeping  = 1'b1;
                  finished  = 1'b0;
               end
               OP_READ: begin
                  if (int'(req_read_band) < BANDS) begin
                     want.energy = energy_bank[req_read_band];
                  end
               end
               OP_SAMPLE: begin
                  if (sweeping) begin
                     want.tone = tone_at(phase_acc);
                     phase_acc = phase_acc + phase_inc;
                     inc_sum   = {1'b0, phase_inc} + 33'(cfg_step);
                     if (inc_sum >= {1'b0, cfg_end}) begin
                        phase_inc = inc_sum[32] ? '1 : inc_sum[31:0];
                        sweeping  = 1'b0;
                        finished  = 1'b1;
                     end else begin
                        span      = (cfg_width == '0) ? 33'h1_0000_0000 : {1'b0, cfg_width};
                        frac_sum  = {1'b0, band_frac} + 33'(cfg_step);
                        adv       = frac_sum / span;
                        next_band = 34'(band_idx) + 34'(adv);
                        if (next_band > 34'(LAST_BAND)) begin
                           next_band = 34'(LAST_BAND);
                        end
                        phase_inc = inc_sum[31:0];
                        band_frac = 32'(frac_sum % span);
                        band_idx  = next_band[7:0];
                        square    = 32'(int'(req_in_sample) * int'(req_in_sample));
                        acc       = 49'(energy_bank[band_idx]) + 49'(square);
                        energy_bank[band_idx] = (acc > 49'(ENERGY_CAP)) ? ENERGY_CAP
                                                                        : acc[47:0];
                     end
                  end
               end
               default: ;
            endcase
            want.done = finished;
            want.band = band_idx;
            expected_words.push_back(want);
         end
      end
      pending_count = expected_words.size();
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ssbe_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic               clock;
   logic               reset;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic [31:0]        csr_data;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_opcode;
   logic signed [15:0] req_in_sample;
   logic [7:0]         req_read_band;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_out_sample;
   logic [47:0]        rsp_band_energy;
   logic               rsp_sweep_done;
   logic [7:0]         rsp_current_band;

   int fail_count;
   int pending_count;

   bit sender_quiet;
   bit rsp_quiet;
   bit pressure_go;

   swept_sine_band_energy u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_in_sample    (req_in_sample),
      .req_read_band    (req_read_band),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_band_energy  (rsp_band_energy),
      .rsp_sweep_done   (rsp_sweep_done),
      .rsp_current_band (rsp_current_band)
   );

   band_energy_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_in_sample    (req_in_sample),
      .req_read_band    (req_read_band),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_band_energy  (rsp_band_energy),
      .rsp_sweep_done   (rsp_sweep_done),
      .rsp_current_band (rsp_current_band),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_word(input logic [1:0] op, input logic [15:0] smp,
                            input logic [7:0] band);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_in_sample <= smp;
      req_read_band <= band;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(input ssbe_reg_type idx, input logic [31:0] value);
      // hold off until any divider run from the last write has finished
      repeat (80) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain_words();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic configure(input logic [31:0] st, input logic [19:0] sp,
                            input logic [31:0] en, input logic [31:0] bw);
      drain_words();
      write_reg(REG_START_INC, st);
      write_reg(REG_END_INC, en);
      write_reg(REG_INC_STEP, 32'(sp));
      write_reg(REG_BAND_WIDTH, bw);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // receiver: random hold per word, plus one long hold on request
   initial begin : drain
      int gap;
      bit took;
      rsp_stall = 1'b0;
      gap = 0;
      forever begin
         @(posedge clock);
         took = rsp_valid && !rsp_stall;
         @(negedge clock);
         if (pressure_go) begin
            pressure_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            gap = 0;
         end else begin
            if (took) begin
               gap = rsp_quiet ? 0 : $urandom_range(0, 10);
            end
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               gap--;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin : stimulus
      int          mode;
      int          lead;
      int          r;
      logic [31:0] st;
      logic [19:0] sp;
      logic [31:0] en;
      logic [31:0] bw;
      logic [63:0] wide;
      reset         = 1'b1;
      csr_write     = 1'b0;
      csr_index     = REG_START_INC;
      csr_data      = '0;
      req_valid     = 1'b0;
      req_opcode    = OP_SAMPLE;
      req_in_sample = '0;
      req_read_band = '0;
      sender_quiet  = 1'b0;
      rsp_quiet     = 1'b0;
      pressure_go   = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // idle block, reset settings
      send_word(OP_SAMPLE, 16'h7FFF, 8'h00);
      send_word(OP_READ, 16'h0000, 8'h00);
      send_word(OP_READ, 16'h0000, 8'hFF);
      send_word(OP_UNUSED, 16'h8000, 8'hAA);
      send_word(OP_START, 16'h0000, 8'h00);
      send_word(OP_SAMPLE, 16'h8000, 8'h00);
      send_word(OP_SAMPLE, 16'h7FFF, 8'hFF);
      send_word(OP_SAMPLE, 16'h0000, 8'h00);
      send_word(OP_SAMPLE, 16'hFFFF, 8'h00);
      send_word(OP_READ, 16'h0000, 8'h00);
      send_word(OP_READ, 16'h5555, 8'h55);
      send_word(OP_UNUSED, 16'h0001, 8'h00);
      // restart while sweeping
      send_word(OP_START, 16'h0000, 8'h00);
      send_word(OP_SAMPLE, 16'h3039, 8'h00);
      send_word(OP_READ, 16'h0000, 8'h00);

      // start already past end, increment saturates
      configure(32'hFFFF_FFFF, INC_STEP_RST, 32'd1, BAND_WIDTH_RST);
      send_word(OP_START, 16'h0000, 8'h00);
      send_word(OP_SAMPLE, 16'h7FFF, 8'h00);
      send_word(OP_SAMPLE, 16'h7FFF, 8'h00);
      send_word(OP_READ, 16'h0000, 8'h00);

      // band index pinned at the top band
      configure(32'd0, 20'hFFFFF, 32'hFFFF_FFFF, 32'd1);
      send_word(OP_START, 16'h0000, 8'h00);
      send_word(OP_SAMPLE, 16'h8000, 8'h00);
      send_word(OP_SAMPLE, 16'h8000, 8'h00);
      send_word(OP_READ, 16'h0000, 8'hFF);

      // zero band width keeps band 0
      configure(32'd0, 20'd1, 32'hFFFF_FFFF, 32'd0);
      sender_quiet = 1'b1;
      rsp_quiet    = 1'b1;
      send_word(OP_START, 16'h0000, 8'h00);
      repeat (20) send_word(OP_SAMPLE, 16'h8000, 8'h00);
      send_word(OP_READ, 16'h0000, 8'h00);
      send_word(OP_READ, 16'h0000, 8'h01);

      for (int p = 0; p < 12; p++) begin
         mode = (p < 6) ? p : $urandom_range(0, 5);
         sp   = 20'($urandom_range(1, 1048575));
         case (mode)
            0: begin
               st   = $urandom;
               wide = 64'(st) + 64'(sp) * 64'($urandom_range(5, 80));
               en   = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
               bw   = $urandom_range(1, 32'(sp) * 4);
            end
            1: begin
               st = 32'hFFFF_FFFF;
               en = 32'd1;
               bw = $urandom;
            end
            2: begin
               st = 32'd0;
               sp = 20'hFFFFF;
               en = 32'hFFFF_FFFF;
               bw = 32'd1;
            end
            3: begin
               st = $urandom;
               sp = 20'd1;
               en = 32'hFFFF_FFFF;
               bw = 32'd0;
            end
            4: begin
               st = $urandom;
               en = $urandom_range(1, 32'hFFFF_FFFF);
               bw = $urandom;
            end
            default: begin
               st = START_INC_RST;
               sp = INC_STEP_RST;
               en = END_INC_RST;
               bw = BAND_WIDTH_RST;
            end
         endcase
         configure(st, sp, en, bw);
         sender_quiet = (p % 4 == 1) || (p == 3);
         rsp_quiet    = (p % 3 == 2);
         lead = $urandom_range(0, 2);
         for (int k = 0; k < 75; k++) begin
            if (p == 3 && k == 4) begin
               pressure_go = 1'b1;
            end
            if (k < lead) begin
               send_word(2'($urandom_range(0, 3)), pick_sample(), 8'($urandom));
            end else if (k == lead) begin
               send_word(OP_START, pick_sample(), 8'($urandom));
            end else begin
               r = $urandom_range(0, 99);
               if (r < 68) begin
                  send_word(OP_SAMPLE, pick_sample(), 8'($urandom));
               end else if (r < 86) begin
                  send_word(OP_READ, 16'($urandom),
                            (r < 77) ? 8'($urandom_range(0, 7)) : 8'($urandom));
               end else if (r < 93) begin
                  send_word(OP_START, pick_sample(), 8'($urandom));
               end else begin
                  send_word(OP_UNUSED, pick_sample(), 8'($urandom));
               end
            end
         end
      end

      drain_words();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
